// ----- hdl/lrgd_pkg.sv -----
// Shared types, constants and helpers for the gradient-descent regression block.
`default_nettype none
package lrgd_pkg;

    localparam int MAX_ROWS       = 256;
    localparam int MAX_WEIGHTS    = 8;
    localparam int MAX_ITERATIONS = 1024;

    localparam int DATA_W     = 32;
    localparam int ACTION_W   = 3;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_WEIGHTS);
    localparam int SLOT_W     = $clog2(MAX_ITERATIONS + 1);
    localparam int ROWS_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int WCNT_W     = $clog2(MAX_WEIGHTS + 1);
    localparam int LR_W       = 16;
    localparam int FEAT_AW    = ROW_W + COL_W;
    localparam int DEN_W      = ROWS_CNT_W + 1;
    localparam int ACC_W      = 56;
    localparam int DIV_CNT_W  = $clog2(ACC_W + 1);
    localparam int FRAC_W     = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE   = 2'd0,
        CFG_ITER_COUNT   = 2'd1,
        CFG_ROWS_USED    = 2'd2,
        CFG_WEIGHTS_USED = 2'd3
    } cfg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        OP_LOAD_FEAT = 3'd0,
        OP_LOAD_TGT  = 3'd1,
        OP_LOAD_W    = 3'd2,
        OP_RUN       = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic {
        KIND_COST   = 1'b0,
        KIND_WEIGHT = 1'b1
    } kind_t;

    typedef struct packed {
        op_t                        op;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic [SLOT_W-1:0]          cslot;
        logic signed [DATA_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic [LR_W-1:0]       learn_rate;
        logic [SLOT_W-1:0]     iteration_count;
        logic [ROWS_CNT_W-1:0] rows_used;
        logic [WCNT_W-1:0]     weights_used;
    } cfg_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
    } front_stat_t;

    typedef struct packed {
        logic in_div;
        logic div_busy;
        logic div_done;
    } back_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ_WAIT,
        S_READ_OUT,
        S_RES_RD,
        S_RES_MUL,
        S_RES_ACC,
        S_RES_WR,
        S_COST_MUL,
        S_COST_ACC,
        S_COST_START,
        S_COST_DIV,
        S_GR_RD,
        S_GR_MUL,
        S_GR_ACC,
        S_GR_START,
        S_GR_DIV,
        S_STEP_MUL,
        S_STEP_UPD,
        S_W_COPY,
        S_OUT_COST,
        S_OUT_W
    } back_state_t;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
        lo = $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
        if (v > hi)
            sat32 = hi[DATA_W-1:0];
        else if (v < lo)
            sat32 = lo[DATA_W-1:0];
        else
            sat32 = v[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/lrgd_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface lrgd_in_if;
    import lrgd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [ROW_W-1:0]          sample_row;
    logic [COL_W-1:0]          feature_col;
    logic [SLOT_W-1:0]         cost_slot;
    logic signed [DATA_W-1:0]  load_value;
    modport source (output valid, action, sample_row, feature_col, cost_slot, load_value,
                    input ready);
    modport sink   (input valid, action, sample_row, feature_col, cost_slot, load_value,
                    output ready);
endinterface

interface lrgd_out_if;
    import lrgd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [DATA_W-1:0]  result_value;
    logic                      last;
    modport source (output valid, kind, slot, result_value, last, input ready);
    modport sink   (input valid, kind, slot, result_value, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/linear_regression_gradient_descent_top.sv -----
// Top level of the batch gradient-descent linear regression block.
//
//  channel   direction  transaction / write
//  in_ch     sink       load feature, load target, load weight, run, read cost
//  out_ch    source     cost or weight result, last marks the final one
//  cfg_*     write      learn_rate, iteration_count, rows_used, weights_used
//
// Loads are executed by the back end while it is idle; the front queue accepts one item a cycle while it has room.
// A read waits on the cost history store, then drives one cost result. A run is paced
// by the shared 32x32 multiplier (read, multiply and accumulate steps for each feature
// product) and the one-bit-a-cycle divider for each mean.
// Reset is asynchronous and active low; the stores are not cleared.
// Output results stall the back end only; the front queue keeps taking items
// until its QUEUE_DEPTH entries are full, then holds in_ch.ready low.
`default_nettype none
module linear_regression_gradient_descent_top (
    input  logic                             clk,
    input  logic                             rst_n,
    lrgd_in_if.sink                          in_ch,
    lrgd_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [lrgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lrgd_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    logic        cmd_valid;
    logic        cmd_ready;
    front_stat_t fstat;
    back_stat_t  bstat;

    // Hold the configuration; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate      <= LR_W'(655);
            cfg_reg.iteration_count <= SLOT_W'(100);
            cfg_reg.rows_used       <= ROWS_CNT_W'(256);
            cfg_reg.weights_used    <= WCNT_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEARN_RATE:   cfg_reg.learn_rate      <= cfg_data[LR_W-1:0];
                CFG_ITER_COUNT:   cfg_reg.iteration_count <= cfg_data[SLOT_W-1:0];
                CFG_ROWS_USED:    cfg_reg.rows_used       <= cfg_data[ROWS_CNT_W-1:0];
                CFG_WEIGHTS_USED: cfg_reg.weights_used    <= cfg_data[WCNT_W-1:0];
            endcase
        end
    end

    // Front: take input transactions, drop unknown actions, queue the rest.
    lrgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (fstat)
    );

    // Back: execute loads, runs and reads; advance through the iterations.
    lrgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .out_ch    (out_ch),
        .stat      (bstat)
    );

`ifndef SYNTH
    // Input stalls only when the command queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> fstat.count == (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("input stalled with room in the queue");

    // The divider works only while the back end waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        bstat.div_busy |-> bstat.in_div)
        else $error("divider busy outside a divide step");

    // A divide step always has a division in flight or finishing.
    assert property (@(posedge clk) disable iff (!rst_n)
        bstat.in_div |-> (bstat.div_busy || bstat.div_done))
        else $error("divide step waiting on an idle divider");
`endif

endmodule
`default_nettype wire

// ----- hdl/lrgd_front.sv -----
// Front end: accept input transactions, classify them and queue commands.
`default_nettype none
module lrgd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    lrgd_in_if.sink              in_ch,
    output lrgd_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output lrgd_pkg::front_stat_t stat
);
    import lrgd_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    cmd_t              cmd_in;
    logic              keep;
    logic              push;
    logic              pop;

    // Drop unknown actions here so the back end never sees them.
    always_comb
    begin
        cmd_in.row   = in_ch.sample_row;
        cmd_in.col   = in_ch.feature_col;
        cmd_in.cslot = in_ch.cost_slot;
        cmd_in.value = in_ch.load_value;
        keep         = 1'b1;
        unique case (in_ch.action)
            OP_LOAD_FEAT: cmd_in.op = OP_LOAD_FEAT;
            OP_LOAD_TGT:  cmd_in.op = OP_LOAD_TGT;
            OP_LOAD_W:    cmd_in.op = OP_LOAD_W;
            OP_RUN:       cmd_in.op = OP_RUN;
            OP_READ:      cmd_in.op = OP_READ;
            default:
            begin
                cmd_in.op = OP_RUN;
                keep      = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready && keep;
    assign cmd_valid   = (count_reg != '0);
    assign pop         = cmd_valid && cmd_ready;
    assign cmd         = q_mem[rd_ptr_reg];
    assign stat.count  = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule
`default_nettype wire

// ----- hdl/lrgd_divider.sv -----
// Serial signed divider: one quotient bit a cycle, truncating toward zero.
`default_nettype none
module lrgd_divider (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [lrgd_pkg::ACC_W-1:0]      dividend,
    input  logic [lrgd_pkg::DEN_W-1:0]             divisor,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [lrgd_pkg::ACC_W-1:0]      quotient
);
    import lrgd_pkg::*;

    logic [ACC_W-1:0]     mag_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W:0]       rem_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh   = {rem_reg[DEN_W-1:0], mag_reg[ACC_W-1]};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(ACC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACC_W-1];
            mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            mag_reg <= {mag_reg[ACC_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/lrgd_back.sv -----
// Back end: execute queued commands, run gradient descent, drive results.
`default_nettype none
module lrgd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrgd_pkg::cfg_t        cfg,
    input  lrgd_pkg::cmd_t        cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    lrgd_out_if.source            out_ch,
    output lrgd_pkg::back_stat_t  stat
);
    import lrgd_pkg::*;

    logic signed [DATA_W-1:0] feat_mem [MAX_ROWS*MAX_WEIGHTS];
    logic signed [DATA_W-1:0] tgt_mem  [MAX_ROWS];
    logic signed [DATA_W-1:0] res_mem  [MAX_ROWS];
    logic signed [DATA_W-1:0] cost_mem [MAX_ITERATIONS+1];
    logic signed [DATA_W-1:0] w_reg    [MAX_WEIGHTS];
    logic signed [DATA_W-1:0] nw_reg   [MAX_WEIGHTS];

    back_state_t state_reg, state_next;

    logic [ROW_W-1:0]  i_reg;
    logic [COL_W-1:0]  j_reg;
    logic [SLOT_W-1:0] it_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              oor_reg;

    logic signed [DATA_W-1:0]   feat_q, tgt_q, res_q, cost_q;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, cacc_reg;
    logic signed [DATA_W-1:0]   res_reg, mean_reg, cost_last_reg;

    logic                       out_valid_reg, out_kind_reg, out_last_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic signed [DATA_W-1:0]   out_value_reg;

    logic [ROWS_CNT_W-1:0] rows_c;
    logic [WCNT_W-1:0]     nw_c;
    logic [SLOT_W-1:0]     iters_c;
    logic                  last_row, last_col, out_free;
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]    prod_sh;
    logic [SLOT_W-1:0]          cost_raddr;

    logic                     div_start, div_busy, div_done;
    logic signed [ACC_W-1:0]  div_dividend, div_q;
    logic [DEN_W-1:0]         div_divisor;

    // Clamp the registers to the supported ranges.
    assign rows_c  = (cfg.rows_used == '0) ? ROWS_CNT_W'(1) :
                     (cfg.rows_used > ROWS_CNT_W'(MAX_ROWS)) ? ROWS_CNT_W'(MAX_ROWS) :
                     cfg.rows_used;
    assign nw_c    = (cfg.weights_used == '0) ? WCNT_W'(1) :
                     (cfg.weights_used > WCNT_W'(MAX_WEIGHTS)) ? WCNT_W'(MAX_WEIGHTS) :
                     cfg.weights_used;
    assign iters_c = (cfg.iteration_count > SLOT_W'(MAX_ITERATIONS)) ?
                     SLOT_W'(MAX_ITERATIONS) : cfg.iteration_count;

    assign last_row = ({1'b0, i_reg} == rows_c - 1'b1);
    assign last_col = ({1'b0, j_reg} == nw_c - 1'b1);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign prod_sh  = ACC_W'(prod_reg >>> FRAC_W);
    // The read slot is latched in idle, so the history read stays put while the queue moves on.
    assign cost_raddr = (slot_reg > SLOT_W'(MAX_ITERATIONS)) ? '0 : slot_reg;

    always_comb
    begin
        unique case (state_reg)
            S_COST_MUL:
            begin
                mul_a = res_reg;
                mul_b = res_reg;
            end
            S_GR_MUL:
            begin
                mul_a = res_q;
                mul_b = feat_q;
            end
            S_STEP_MUL:
            begin
                mul_a = mean_reg;
                mul_b = $signed(DATA_W'(cfg.learn_rate));
            end
            default:
            begin
                mul_a = feat_q;
                mul_b = w_reg[j_reg];
            end
        endcase
    end

    always_comb
    begin
        div_start    = (state_reg == S_COST_START) || (state_reg == S_GR_START);
        div_dividend = (state_reg == S_COST_START) ? cacc_reg : acc_reg;
        div_divisor  = (state_reg == S_COST_START) ? {rows_c, 1'b0} : {1'b0, rows_c};
    end

    lrgd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && cmd.op == OP_RUN)
                    state_next = S_RES_RD;
                else if (cmd_valid && cmd.op == OP_READ)
                    state_next = S_READ_WAIT;
            end
            S_READ_WAIT:  state_next = S_READ_OUT;
            S_READ_OUT:   if (out_free) state_next = S_IDLE;
            S_RES_RD:     state_next = S_RES_MUL;
            S_RES_MUL:    state_next = S_RES_ACC;
            S_RES_ACC:    state_next = last_col ? S_RES_WR : S_RES_RD;
            S_RES_WR:     state_next = S_COST_MUL;
            S_COST_MUL:   state_next = S_COST_ACC;
            S_COST_ACC:   state_next = last_row ? S_COST_START : S_RES_RD;
            S_COST_START: state_next = S_COST_DIV;
            S_COST_DIV:
                if (div_done)
                    state_next = (it_reg == iters_c) ? S_OUT_COST : S_GR_RD;
            S_GR_RD:      state_next = S_GR_MUL;
            S_GR_MUL:     state_next = S_GR_ACC;
            S_GR_ACC:     state_next = last_row ? S_GR_START : S_GR_RD;
            S_GR_START:   state_next = S_GR_DIV;
            S_GR_DIV:     if (div_done) state_next = S_STEP_MUL;
            S_STEP_MUL:   state_next = S_STEP_UPD;
            S_STEP_UPD:   state_next = last_col ? S_W_COPY : S_GR_RD;
            S_W_COPY:     state_next = S_RES_RD;
            S_OUT_COST:   if (out_free) state_next = S_OUT_W;
            S_OUT_W:      if (out_free && last_col) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Counters and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    i_reg  <= '0;
                    j_reg  <= '0;
                    it_reg <= '0;
                end
                S_READ_OUT:
                    if (out_free)
                        out_valid_reg <= 1'b1;
                S_RES_ACC:
                    if (!last_col)
                        j_reg <= j_reg + 1'b1;
                S_COST_ACC:
                    if (!last_row)
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= '0;
                    end
                S_COST_DIV:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                S_GR_ACC:
                    if (!last_row)
                        i_reg <= i_reg + 1'b1;
                S_STEP_UPD:
                begin
                    i_reg <= '0;
                    j_reg <= last_col ? '0 : j_reg + 1'b1;
                end
                S_W_COPY:
                    it_reg <= it_reg + 1'b1;
                S_OUT_COST:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        j_reg         <= '0;
                    end
                S_OUT_W:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        j_reg         <= j_reg + 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath, memories and output payload.
    always_ff @(posedge clk)
    begin
        feat_q   <= feat_mem[{i_reg, j_reg}];
        tgt_q    <= tgt_mem[i_reg];
        res_q    <= res_mem[i_reg];
        cost_q   <= cost_mem[cost_raddr];
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                acc_reg  <= '0;
                cacc_reg <= '0;
                slot_reg <= cmd.cslot;
                oor_reg  <= (cmd.cslot > SLOT_W'(MAX_ITERATIONS));
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_LOAD_FEAT: feat_mem[{cmd.row, cmd.col}] <= cmd.value;
                        OP_LOAD_TGT:  tgt_mem[cmd.row] <= cmd.value;
                        OP_LOAD_W:    w_reg[cmd.col] <= cmd.value;
                        OP_RUN, OP_READ:
                        begin
                        end
                    endcase
                end
            end
            S_READ_OUT:
                if (out_free)
                begin
                    out_kind_reg  <= KIND_COST;
                    out_slot_reg  <= slot_reg;
                    out_value_reg <= oor_reg ? '0 : cost_q;
                    out_last_reg  <= 1'b1;
                end
            S_RES_ACC:
                acc_reg <= acc_reg + prod_sh;
            S_RES_WR:
            begin
                res_reg        <= sat32(acc_reg - ACC_W'(tgt_q));
                res_mem[i_reg] <= sat32(acc_reg - ACC_W'(tgt_q));
                acc_reg        <= '0;
            end
            S_COST_ACC:
                cacc_reg <= cacc_reg + prod_sh;
            S_COST_DIV:
                if (div_done)
                begin
                    cost_mem[it_reg] <= sat32(div_q);
                    cost_last_reg    <= sat32(div_q);
                    acc_reg          <= '0;
                end
            S_GR_ACC:
                acc_reg <= acc_reg + prod_sh;
            S_GR_DIV:
                if (div_done)
                    mean_reg <= sat32(div_q);
            S_STEP_UPD:
            begin
                nw_reg[j_reg] <= sat32(ACC_W'(w_reg[j_reg]) - prod_sh);
                acc_reg       <= '0;
            end
            S_W_COPY:
            begin
                // Advance only the weights in use; the rest keep their loaded values.
                for (int k = 0; k < MAX_WEIGHTS; k++)
                    if (WCNT_W'(k) < nw_c)
                        w_reg[k] <= nw_reg[k];
                acc_reg  <= '0;
                cacc_reg <= '0;
            end
            S_OUT_COST:
                if (out_free)
                begin
                    out_kind_reg  <= KIND_COST;
                    out_slot_reg  <= iters_c;
                    out_value_reg <= cost_last_reg;
                    out_last_reg  <= 1'b0;
                end
            S_OUT_W:
                if (out_free)
                begin
                    out_kind_reg  <= KIND_WEIGHT;
                    out_slot_reg  <= SLOT_W'(j_reg);
                    out_value_reg <= w_reg[j_reg];
                    out_last_reg  <= last_col;
                end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.slot         = out_slot_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.last         = out_last_reg;

    assign stat.in_div   = (state_reg == S_COST_DIV) || (state_reg == S_GR_DIV);
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

endmodule
`default_nettype wire
